// ===== src/assert_macros.svh =====
// Concurrent assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/ppt_pkg.sv =====
`default_nettype none
package ppt_pkg;

   localparam int POS_W       = 22;
   localparam int SUM_W       = 23;
   localparam int NUM_W       = 20;
   localparam int SIZE_W      = 11;
   localparam int BYTE_W      = 8;
   localparam int SCALE_STEPS = 8;
   localparam int CNT_W       = 3;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCALE_STEPS - 1);

   localparam logic KIND_MOVE   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [1:0] DIR_STILL = 2'd0;
   localparam logic [1:0] DIR_FWD   = 2'd1;
   localparam logic [1:0] DIR_BACK  = 2'd2;

   localparam logic [2:0] REG_DIAL_MODE     = 3'd0;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd1;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd2;
   localparam logic [2:0] REG_WRAP_X_LOW    = 3'd3;
   localparam logic [2:0] REG_WRAP_X_HIGH   = 3'd4;
   localparam logic [2:0] REG_WRAP_Y_LOW    = 3'd5;
   localparam logic [2:0] REG_WRAP_Y_HIGH   = 3'd6;

   localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = 11'd320;
   localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = 11'd240;
   localparam logic [7:0]        RST_WRAP_LOW      = 8'd0;
   localparam logic [7:0]        RST_WRAP_HIGH     = 8'd240;

   // Pointer start: (320/2 - 7) and (240/2 - 8) pixels in signed 14.8
   localparam logic signed [POS_W-1:0] RST_POS_X = 22'sd39168;
   localparam logic signed [POS_W-1:0] RST_POS_Y = 22'sd28672;

   // Clamp floor sits 8 pixels left of / above the screen
   localparam logic signed [SUM_W-1:0] CLAMP_LO   = -23'sd2048;
   localparam logic signed [POS_W-1:0] CLAMP_LO_P = -22'sd2048;

   typedef struct packed {
      logic              dial_mode;
      logic [SIZE_W-1:0] screen_width;
      logic [SIZE_W-1:0] screen_height;
      logic [7:0]        wrap_x_low;
      logic [7:0]        wrap_x_high;
      logic [7:0]        wrap_y_low;
      logic [7:0]        wrap_y_high;
   } ppt_cfg_type;

   typedef struct packed {
      logic capture;
      logic add;
      logic limit;
      logic prep;
      logic load;
      logic step;
      logic finish;
   } ppt_cmd_type;

   typedef struct packed {
      logic out_free;
   } ppt_status_type;

endpackage
`default_nettype wire

// ===== src/pointer_position_tracker_unit.sv =====
`default_nettype none
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata: delta_x, delta_y; tuser: kind, player
// rsp       out  rsp_tvalid/rsp_tready  tdata: pos bytes, dial speeds and directions
// csr       in   APB psel/penable       seven registers at byte address 4*i
//
// An item runs from acceptance through four setup steps,
// then 8 steps of the restoring dividers (one quotient bit per cycle) that scale
// each axis, then a load of the result register; only then is the next item accepted.
// Reset is synchronous, active high; it returns every pointer to its start point.
// A waiting result does not block the next item; the block holds its last step
// only while the result register is still full and not being taken.
module pointer_position_tracker_unit
   import ppt_pkg::*;
#(
   parameter int PLAYERS = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // delta_x, delta_y
   input  wire logic [2:0]  req_tuser,   // kind, player
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // pos_x_byte, pos_y_byte, dial_a_speed,
                                         // dial_a_dir, dial_b_speed, dial_b_dir
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   ppt_cfg_type    cfg;
   ppt_cmd_type    cmd;
   ppt_status_type status;

   ppt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ppt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppt_dpath #(
      .PLAYERS (PLAYERS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== src/ppt_csr.sv =====
`default_nettype none
module ppt_csr
   import ppt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output ppt_cfg_type      cfg
);

   ppt_cfg_type cfg_ff;
   ppt_cfg_type cfg_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DIAL_MODE:     cfg_in.dial_mode     = csr_pwdata[0];
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[SIZE_W-1:0];
            REG_WRAP_X_LOW:    cfg_in.wrap_x_low    = csr_pwdata[7:0];
            REG_WRAP_X_HIGH:   cfg_in.wrap_x_high   = csr_pwdata[7:0];
            REG_WRAP_Y_LOW:    cfg_in.wrap_y_low    = csr_pwdata[7:0];
            REG_WRAP_Y_HIGH:   cfg_in.wrap_y_high   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DIAL_MODE:     csr_prdata = 32'(cfg_ff.dial_mode);
         REG_SCREEN_WIDTH:  csr_prdata = 32'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = 32'(cfg_ff.screen_height);
         REG_WRAP_X_LOW:    csr_prdata = 32'(cfg_ff.wrap_x_low);
         REG_WRAP_X_HIGH:   csr_prdata = 32'(cfg_ff.wrap_x_high);
         REG_WRAP_Y_LOW:    csr_prdata = 32'(cfg_ff.wrap_y_low);
         REG_WRAP_Y_HIGH:   csr_prdata = 32'(cfg_ff.wrap_y_high);
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dial_mode     <= 1'b0;
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.wrap_x_low    <= RST_WRAP_LOW;
         cfg_ff.wrap_x_high   <= RST_WRAP_HIGH;
         cfg_ff.wrap_y_low    <= RST_WRAP_LOW;
         cfg_ff.wrap_y_high   <= RST_WRAP_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/ppt_div.sv =====
`default_nettype none
module ppt_div
   import ppt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic              step,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [SIZE_W-1:0] divisor,
   output logic      [BYTE_W-1:0] quot
);

   // Restoring divider, one quotient bit per step. The caller guarantees
   // num < divisor * 256, so the upper numerator bits start below divisor.
   logic [SIZE_W-1:0] rem_ff;
   logic [SIZE_W-1:0] rem_in;
   logic [BYTE_W-1:0] shift_ff;
   logic [BYTE_W-1:0] shift_in;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;
   logic              ge;

   assign trial = {rem_ff, shift_ff[BYTE_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign ge    = trial >= {1'b0, divisor};
   assign quot  = shift_ff;

   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (load) begin
         rem_in   = num[NUM_W-2:BYTE_W];
         shift_in = num[BYTE_W-1:0];
      end else if (step) begin
         rem_in   = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
         shift_in = {shift_ff[BYTE_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

endmodule
`default_nettype wire

// ===== src/ppt_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module ppt_ctrl
   import ppt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire ppt_status_type status,
   output ppt_cmd_type         cmd
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ADD   = 7'b0000010,
      ST_LIMIT = 7'b0000100,
      ST_PREP  = 7'b0001000,
      ST_LOAD  = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // take no item while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register can take the item
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `ASSERT_NEXT(a_div_start, clock, reset, state_ff == ST_LOAD, state_ff == ST_DIV && cnt_ff == '0, "divider did not start from step zero")
   `ASSERT_NEXT(a_no_accept_busy, clock, reset, cmd.capture, !req_tready && state_ff == ST_ADD, "item accepted while busy")

endmodule
`default_nettype wire

// ===== src/ppt_dpath.sv =====
`default_nettype none
`include "assert_macros.svh"
module ppt_dpath
   import ppt_pkg::*;
#(
   parameter int PLAYERS = 4
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ppt_cmd_type    cmd,
   output ppt_status_type      status,
   input  wire ppt_cfg_type    cfg,
   input  wire logic [2:0]     req_tuser,
   input  wire logic [31:0]    req_tdata,
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic      [39:0]    rsp_tdata
);

   localparam int IDX_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
   localparam logic [3:0] PLAYER_COUNT = 4'(PLAYERS);

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic                    wrapped;
      logic [7:0]              smp;
   } lim_type;

   typedef struct packed {
      logic [7:0] spd;
      logic [1:0] dir;
   } take_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic             nonpos;
   } prep_type;

   function automatic logic signed [15:0] dead_zone(input logic signed [15:0] d,
                                                    input logic kill);
      return (kill || d == 16'sd1 || d == -16'sd1) ? 16'sd0 : d;
   endfunction

   // floor(p/256) truncated toward zero by 4, low byte
   function automatic logic [7:0] dial_sample(input logic signed [POS_W-1:0] p);
      logic signed [13:0] w;
      logic signed [13:0] b;
      w = signed'(p[POS_W-1:8]);
      b = w[13] ? w + 14'sd3 : w;
      return b[9:2];
   endfunction

   function automatic take_type dial_take(input logic [7:0] s, input logic [7:0] last);
      take_type r;
      r.spd = 8'd0;
      r.dir = DIR_STILL;
      if (s < last) begin
         r.spd = last - s;
         r.dir = DIR_BACK;
      end else if (s > last) begin
         r.spd = s - last;
         r.dir = DIR_FWD;
      end
      return r;
   endfunction

   function automatic lim_type limit_axis(input logic signed [SUM_W-1:0] p,
                                          input logic dial,
                                          input logic [SIZE_W-1:0] size,
                                          input logic [7:0] lo16,
                                          input logic [7:0] hi16);
      logic signed [SUM_W-1:0] lo;
      logic signed [SUM_W-1:0] hi;
      lim_type r;
      if (dial) begin
         lo = signed'({3'b000, lo16, 12'h000});
         hi = signed'({3'b000, hi16, 12'h000});
      end else begin
         lo = CLAMP_LO;
         hi = signed'({4'b0000, size, 8'h00}) + CLAMP_LO;
      end
      r.pos     = p[POS_W-1:0];
      r.wrapped = 1'b0;
      r.smp     = 8'd0;
      if (dial) begin
         // a wrap lands on a bound, whose dial sample is bound*4
         if (p < lo) begin
            r.pos     = hi[POS_W-1:0];
            r.wrapped = 1'b1;
            r.smp     = {hi16[5:0], 2'b00};
         end else if (p > hi) begin
            r.pos     = lo[POS_W-1:0];
            r.wrapped = 1'b1;
            r.smp     = {lo16[5:0], 2'b00};
         end
      end else begin
         if (p < lo) begin
            r.pos = lo[POS_W-1:0];
         end else if (p > hi) begin
            r.pos = hi[POS_W-1:0];
         end
      end
      return r;
   endfunction

   // (floor(p/256) + 8) * 255
   function automatic prep_type prep_axis(input logic signed [POS_W-1:0] p);
      logic signed [14:0] v;
      prep_type r;
      v        = 15'(signed'(p[POS_W-1:8])) + 15'sd8;
      r.nonpos = v[14] || (v == 15'sd0);
      r.num    = {v[11:0], 8'h00} - {8'h00, v[11:0]};
      return r;
   endfunction

   // item capture
   logic                    kind_ff;
   logic                    ok_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic signed [15:0]      dx_ff;
   logic signed [15:0]      dy_ff;
   logic [1:0]              player;
   logic                    kind;

   // per player state
   logic signed [POS_W-1:0] pos_x_ff  [PLAYERS];
   logic signed [POS_W-1:0] pos_y_ff  [PLAYERS];
   logic [7:0]              last_a_ff [PLAYERS];
   logic [7:0]              last_b_ff [PLAYERS];

   logic signed [SUM_W-1:0] sum_x_ff;
   logic signed [SUM_W-1:0] sum_y_ff;
   logic signed [POS_W-1:0] posr_x_ff;
   logic signed [POS_W-1:0] posr_y_ff;
   logic [7:0]              spd_a_ff;
   logic [7:0]              spd_b_ff;
   logic [1:0]              dir_a_ff;
   logic [1:0]              dir_b_ff;

   logic [NUM_W-1:0]        num_x_ff;
   logic [NUM_W-1:0]        num_y_ff;
   logic                    nonpos_x_ff;
   logic                    nonpos_y_ff;
   logic                    spec_x_ff;
   logic                    spec_y_ff;
   logic [7:0]              specv_x_ff;
   logic [7:0]              specv_y_ff;

   logic                    rsp_valid_ff;
   logic [39:0]             rsp_data_ff;
   logic [39:0]             rsp_data_in;

   lim_type                 lim_x;
   lim_type                 lim_y;
   take_type                take_a;
   take_type                take_b;
   prep_type                prep_x;
   prep_type                prep_y;
   logic [7:0]              smp_a;
   logic [7:0]              smp_b;
   logic                    do_move;
   logic                    do_sample;
   logic                    zs_x;
   logic                    zs_y;
   logic                    sat_x;
   logic                    sat_y;
   logic [7:0]              quot_x;
   logic [7:0]              quot_y;
   logic [7:0]              byte_x;
   logic [7:0]              byte_y;
   logic signed [POS_W-1:0] wx_lo;
   logic signed [POS_W-1:0] wx_hi;

   assign kind   = req_tuser[0];
   assign player = req_tuser[2:1];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind;
         ok_ff   <= {2'b00, player} < PLAYER_COUNT;
         idx_ff  <= IDX_W'({{IDX_W{1'b0}}, player});
         // sample items carry no motion
         dx_ff   <= dead_zone(signed'(req_tdata[15:0]), kind == KIND_SAMPLE);
         dy_ff   <= dead_zone(signed'(req_tdata[31:16]), kind == KIND_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add) begin
         sum_x_ff <= SUM_W'(pos_x_ff[idx_ff]) + SUM_W'(dx_ff);
         sum_y_ff <= SUM_W'(pos_y_ff[idx_ff]) + SUM_W'(dy_ff);
      end
   end

   assign do_move   = ok_ff && (kind_ff == KIND_MOVE);
   assign do_sample = ok_ff && (kind_ff == KIND_SAMPLE);

   assign lim_x  = limit_axis(sum_x_ff, cfg.dial_mode, cfg.screen_width,
                              cfg.wrap_x_low, cfg.wrap_x_high);
   assign lim_y  = limit_axis(sum_y_ff, cfg.dial_mode, cfg.screen_height,
                              cfg.wrap_y_low, cfg.wrap_y_high);
   assign smp_a  = dial_sample(sum_x_ff[POS_W-1:0]);
   assign smp_b  = dial_sample(sum_y_ff[POS_W-1:0]);
   assign take_a = dial_take(smp_a, last_a_ff[idx_ff]);
   assign take_b = dial_take(smp_b, last_b_ff[idx_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLAYERS; i++) begin
            pos_x_ff[i]  <= RST_POS_X;
            pos_y_ff[i]  <= RST_POS_Y;
            last_a_ff[i] <= 8'd0;
            last_b_ff[i] <= 8'd0;
         end
         spd_a_ff <= 8'd0;
         spd_b_ff <= 8'd0;
         dir_a_ff <= DIR_STILL;
         dir_b_ff <= DIR_STILL;
      end else if (cmd.limit) begin
         if (do_move) begin
            pos_x_ff[idx_ff] <= cfg.dial_mode ? lim_x.pos : lim_x.pos;
            pos_y_ff[idx_ff] <= lim_y.pos;
            if (lim_x.wrapped) begin
               last_a_ff[idx_ff] <= lim_x.smp;
            end
            if (lim_y.wrapped) begin
               last_b_ff[idx_ff] <= lim_y.smp;
            end
         end
         if (do_sample) begin
            last_a_ff[idx_ff] <= smp_a;
            last_b_ff[idx_ff] <= smp_b;
            spd_a_ff <= take_a.spd;
            spd_b_ff <= take_b.spd;
            dir_a_ff <= take_a.dir;
            dir_b_ff <= take_b.dir;
         end else begin
            spd_a_ff <= 8'd0;
            spd_b_ff <= 8'd0;
            dir_a_ff <= DIR_STILL;
            dir_b_ff <= DIR_STILL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.limit) begin
         posr_x_ff <= (kind_ff == KIND_MOVE) ? lim_x.pos : sum_x_ff[POS_W-1:0];
         posr_y_ff <= (kind_ff == KIND_MOVE) ? lim_y.pos : sum_y_ff[POS_W-1:0];
      end
   end

   assign prep_x = prep_axis(posr_x_ff);
   assign prep_y = prep_axis(posr_y_ff);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         num_x_ff    <= prep_x.num;
         num_y_ff    <= prep_y.num;
         nonpos_x_ff <= prep_x.nonpos;
         nonpos_y_ff <= prep_y.nonpos;
      end
   end

   assign zs_x  = cfg.screen_width == '0;
   assign zs_y  = cfg.screen_height == '0;
   assign sat_x = num_x_ff >= {1'b0, cfg.screen_width, 8'h00};
   assign sat_y = num_y_ff >= {1'b0, cfg.screen_height, 8'h00};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         spec_x_ff  <= zs_x || nonpos_x_ff || sat_x;
         spec_y_ff  <= zs_y || nonpos_y_ff || sat_y;
         specv_x_ff <= (nonpos_x_ff && !zs_x) ? 8'h00 : 8'hff;
         specv_y_ff <= (nonpos_y_ff && !zs_y) ? 8'h00 : 8'hff;
      end
   end

   ppt_div u_div_x (
      .clock   (clock),
      .load    (cmd.load),
      .step    (cmd.step),
      .num     (num_x_ff),
      .divisor (cfg.screen_width),
      .quot    (quot_x)
   );

   ppt_div u_div_y (
      .clock   (clock),
      .load    (cmd.load),
      .step    (cmd.step),
      .num     (num_y_ff),
      .divisor (cfg.screen_height),
      .quot    (quot_y)
   );

   assign byte_x = !ok_ff ? 8'hff : (spec_x_ff ? specv_x_ff : quot_x);
   assign byte_y = !ok_ff ? 8'hff : (spec_y_ff ? specv_y_ff : quot_y);

   assign rsp_data_in = {4'h0, dir_b_ff, spd_b_ff, dir_a_ff, spd_a_ff, byte_y, byte_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign wx_lo = signed'({2'b00, cfg.wrap_x_low, 12'h000});
   assign wx_hi = signed'({2'b00, cfg.wrap_x_high, 12'h000});

   `ASSERT_ALWAYS(a_no_overrun, clock, reset, !(cmd.finish && rsp_valid_ff && !rsp_tready), "result overwritten before taken")
   `ASSERT_NEXT(a_clamp_floor, clock, reset, cmd.limit && do_move && !cfg.dial_mode, posr_x_ff >= CLAMP_LO_P && posr_y_ff >= CLAMP_LO_P, "clamped position below floor")
   `ASSERT_NEXT(a_wrap_span, clock, reset, cmd.limit && do_move && cfg.dial_mode && (cfg.wrap_x_low <= cfg.wrap_x_high), posr_x_ff >= wx_lo && posr_x_ff <= wx_hi, "wrapped position outside bounds")
   `ASSERT_ALWAYS(a_dir_speed, clock, reset, (dir_a_ff == DIR_STILL) == (spd_a_ff == 8'd0), "dial direction disagrees with speed")

endmodule
`default_nettype wire
